// File: hdl/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types and constants for the system stream demux.
// ----------------------------------------------------------------------------
package mssd_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_PTS     = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SYNC      = 2'd0,
    ERR_STREAM_ID = 2'd1,
    ERR_PACK      = 2'd2,
    ERR_NOT_SYS   = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_SKIP    = 4'd0,
    PH_DATA    = 4'd1,
    PH_HUNT    = 4'd2,
    PH_TSHDR   = 4'd3,
    PH_PACK    = 4'd4,
    PH_OTHER   = 4'd5,
    PH_PES     = 4'd6,
    PH_PES2    = 4'd7,
    PH_PES1S   = 4'd8,
    PH_PES1STD = 4'd9,
    PH_PES1X   = 4'd10
  } phase_t;

  localparam logic [7:0]  SYNC_BYTE  = 8'h47;
  localparam logic [7:0]  SID_END    = 8'hb9;
  localparam logic [7:0]  SID_PACK   = 8'hba;
  localparam logic [7:0]  SID_VID_LO = 8'he0;
  localparam logic [7:0]  SID_VID_HI = 8'hef;

  localparam logic [1:0] ADDR_PID   = 2'd0;
  localparam logic [1:0] ADDR_TRACK = 2'd1;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] pts;
    err_t        err;
  } result_t;

endpackage

// File: hdl/mpeg_system_stream_demux.sv
// A byte in the input register is parsed when the parser steps; any result word
// is registered in the output slot and offered on out_valid until taken.
// Throughput: one byte per cycle while words are taken; a waiting word stalls the
// parser, and the input register then holds one more byte.
// The parser state is updated once per byte from the input register.
// rst (sync): all but data regs cleared, parser in skip, start code shift all ones.
// ----------------------------------------------------------------------------
// mpeg_system_stream_demux
// Byte-wide MPEG transport/program stream demux to the video elementary stream.
// ----------------------------------------------------------------------------
module mpeg_system_stream_demux #(
  parameter int TS_PACKET_BYTES = 188
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic [31:0] pts_value,
  output logic [1:0]  error_code
);
  import mssd_pkg::*;

  logic [12:0] transport_pid;
  logic [7:0]  stream_track;
  logic        ib_valid;
  logic [7:0]  ib_data;
  logic        step;
  result_t     res;
  result_t     ob;

  mssd_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .transport_pid, .stream_track
  );

  // input word moves into the parser when the output slot can take its result
  assign step = ib_valid && (!ob.valid || out_ready);
  assign in_ready = !ib_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_ready) begin
      ib_valid <= in_valid;
    end
    if (in_ready && in_valid) ib_data <= stream_byte;
  end

  mssd_parser #(.TS_PACKET_BYTES(TS_PACKET_BYTES)) u_parser (
    .clk, .rst, .step, .b(ib_data), .transport_pid, .stream_track, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ob.valid <= 1'b0;
    end else if (!ob.valid || out_ready) begin
      ob.valid <= res.valid;
    end
    if (!ob.valid || out_ready) begin
      ob.kind <= res.kind;
      ob.data <= res.data;
      ob.pts  <= res.pts;
      ob.err  <= res.err;
    end
  end

  assign out_valid    = ob.valid;
  assign result_kind  = ob.kind;
  assign payload_byte = ob.data;
  assign pts_value    = ob.pts;
  assign error_code   = ob.err;
endmodule

// File: hdl/mssd_regs.sv
// ----------------------------------------------------------------------------
// mssd_regs
// APB register file holding the PID and track selects.
// ----------------------------------------------------------------------------
module mssd_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [12:0] transport_pid,
  output logic [7:0]  stream_track
);
  import mssd_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transport_pid <= '0;
      stream_track  <= '0;
    end else if (wr) begin
      if ({1'b0, paddr[2]} == ADDR_PID && paddr[1:0] == 2'b00) begin
        transport_pid <= pwdata[12:0];
      end
      if ({1'b0, paddr[2]} == ADDR_TRACK && paddr[1:0] == 2'b00) begin
        stream_track <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if ({1'b0, paddr[2]} == ADDR_PID && paddr[1:0] == 2'b00) begin
      prdata = {19'd0, transport_pid};
    end else if ({1'b0, paddr[2]} == ADDR_TRACK && paddr[1:0] == 2'b00) begin
      prdata = {24'd0, stream_track};
    end
  end
endmodule

// File: hdl/mssd_parser.sv
// ----------------------------------------------------------------------------
// mssd_parser
// Per-byte stream parser: packet framing, PES header walk, result select.
// ----------------------------------------------------------------------------
module mssd_parser #(
  parameter int TS_PACKET_BYTES = 188
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        b,
  input  logic [12:0]       transport_pid,
  input  logic [7:0]        stream_track,
  output mssd_pkg::result_t res
);
  import mssd_pkg::*;

  localparam logic [8:0] PKT = 9'(TS_PACKET_BYTES);

  logic [7:0]  packet_position, packet_position_next;
  logic [3:0]  packet_flags, packet_flags_next;
  logic [7:0]  adaptation_skip, adaptation_skip_next;
  phase_t      parse_phase, parse_phase_next;
  logic [23:0] start_code_shift, start_code_shift_next;
  logic [8:0]  header_index, header_index_next;
  logic [8:0]  header_target, header_target_next;
  logic [16:0] remaining_bytes, remaining_bytes_next;
  logic [31:0] pts_accumulator, pts_accumulator_next;
  logic [3:0]  header_flags, header_flags_next;
  logic [15:0] pes_length, pes_length_next;
  logic [4:0]  pid_high, pid_high_next;

  phase_t      ph;
  logic        ts;
  logic [8:0]  pos, idx, f, o, start;
  logic [17:0] d;
  logic [3:0]  extra;
  logic        dsp;
  logic        pdone;
  logic [8:0]  pdone_len;
  logic        pflag;
  logic [8:0]  pflag_idx;
  logic        pstuff;
  logic        parse_en;
  logic        pbegin;
  logic        pbegin_us;

  always_comb begin
    packet_position_next  = packet_position;
    packet_flags_next     = packet_flags;
    adaptation_skip_next  = adaptation_skip;
    parse_phase_next      = parse_phase;
    start_code_shift_next = start_code_shift;
    header_index_next     = header_index;
    header_target_next    = header_target;
    remaining_bytes_next  = remaining_bytes;
    pts_accumulator_next  = pts_accumulator;
    header_flags_next     = header_flags;
    pes_length_next       = pes_length;
    pid_high_next         = pid_high;
    res = '0;
    ts = transport_pid != 13'd0;
    ph = parse_phase;
    pos = {1'b0, packet_position};
    idx = header_index;
    f = '0;
    o = '0;
    start = '0;
    d = '0;
    extra = '0;
    dsp = 1'b0;
    pdone = 1'b0;
    pdone_len = '0;
    pflag = 1'b0;
    pflag_idx = '0;
    pstuff = 1'b0;
    parse_en = 1'b0;
    pbegin = 1'b0;
    pbegin_us = 1'b0;

    if (ts) begin
      if (pos >= PKT) pos = '0;
      if (pos == 9'd0) begin
        if (b != SYNC_BYTE) begin
          packet_position_next = '0;
          res = '{1'b1, KIND_ERROR, 8'd0, 32'd0, ERR_SYNC};
        end else begin
          packet_flags_next = '0;
          adaptation_skip_next = '0;
          packet_position_next = 8'd1;
        end
      end else begin
        packet_position_next = (pos + 9'd1 >= PKT) ? 8'd0 : 8'(pos + 9'd1);
        if (pos == 9'd1) begin
          pid_high_next = b[4:0];
          packet_flags_next = {3'b000, b[6]};
        end else if (pos == 9'd2) begin
          if ({pid_high, b} == transport_pid) packet_flags_next[3] = 1'b1;
        end else if (pos == 9'd3) begin
          if (packet_flags[3]) begin
            if (b[4]) packet_flags_next[2] = 1'b1;
            if (b[5]) begin
              packet_flags_next[1] = 1'b1;
            end else if (b[4]) begin
              pbegin = 1'b1;
              pbegin_us = packet_flags[0];
              adaptation_skip_next = 8'd4;
            end
          end
        end else if (pos == 9'd4 && packet_flags[1]) begin
          start = 9'd5 + 9'(b);
          if (packet_flags[2] && start <= PKT) begin
            pbegin = 1'b1;
            pbegin_us = packet_flags[0];
            if (start < PKT) adaptation_skip_next = start[7:0];
          end
        end else if (adaptation_skip != 8'd0 && pos >= {1'b0, adaptation_skip}) begin
          parse_en = 1'b1;
        end
      end
      if (pbegin) begin
        if (pbegin_us) begin
          parse_phase_next = PH_TSHDR;
          header_index_next = '0;
        end else if (parse_phase == PH_TSHDR && header_index == 9'd0) begin
          parse_phase_next = PH_SKIP;
        end
      end
    end else if (stream_track != 8'd0) begin
      parse_en = 1'b1;
    end else begin
      res = '{1'b1, KIND_PAYLOAD, b, 32'd0, ERR_SYNC};
    end

    if (parse_en) begin
      if (ts && ph == PH_HUNT) ph = PH_SKIP;
      if (!ts && ph == PH_TSHDR) ph = PH_HUNT;
      parse_phase_next = ph;
      if (ph == PH_DATA || ph == PH_SKIP) begin
        if (ts) begin
          if (ph == PH_DATA) res = '{1'b1, KIND_PAYLOAD, b, 32'd0, ERR_SYNC};
        end else if (remaining_bytes != '0) begin
          remaining_bytes_next = remaining_bytes - 17'd1;
          if (remaining_bytes == 17'd1) parse_phase_next = PH_HUNT;
          if (ph == PH_DATA) res = '{1'b1, KIND_PAYLOAD, b, 32'd0, ERR_SYNC};
        end else begin
          ph = PH_HUNT;
          parse_phase_next = PH_HUNT;
        end
      end
      if (ph == PH_HUNT) begin
        if (start_code_shift == 24'd1) begin
          start_code_shift_next = 24'hffffff;
          dsp = 1'b1;
        end else begin
          start_code_shift_next = {start_code_shift[15:0], b};
        end
      end else if (ph != PH_DATA && ph != PH_SKIP) begin
        header_index_next = idx + 9'd1;
        case (ph)
          PH_TSHDR: begin
            if ((idx < 9'd2 && b != 8'd0) || (idx == 9'd2 && b != 8'd1)) begin
              parse_phase_next = PH_SKIP;
            end else if (idx >= 9'd3) begin
              dsp = 1'b1;
            end
          end
          PH_PACK: begin
            if (idx == 9'd4) begin
              header_flags_next = (b[7:6] == 2'b01) ? 4'd1 :
                                  ((b[7:4] == 4'h2) ? 4'd2 : 4'd0);
            end
            if (idx == 9'd11 && header_flags != 4'd1) begin
              parse_phase_next = PH_HUNT;
              if (header_flags != 4'd2) res = '{1'b1, KIND_ERROR, 8'd0, 32'd0, ERR_PACK};
            end else begin
              if (idx == 9'd13) header_target_next = 9'd14 + 9'(b[2:0]);
              if (idx >= 9'd13 && idx + 9'd1 >= header_target_next)
                parse_phase_next = PH_HUNT;
            end
          end
          PH_OTHER: begin
            if (idx == 9'd4) begin
              remaining_bytes_next = {1'b0, b, 8'd0};
            end else if (idx >= 9'd5) begin
              remaining_bytes_next = remaining_bytes | 17'(b);
              parse_phase_next = (remaining_bytes_next != '0) ? PH_SKIP : PH_HUNT;
            end
          end
          PH_PES: begin
            if (idx == 9'd4) pes_length_next = {b, 8'd0};
            else if (idx == 9'd5) pes_length_next = pes_length | 16'(b);
            else if (idx >= 9'd6) begin
              if (b[7:6] == 2'b10) parse_phase_next = PH_PES2;
              else pstuff = 1'b1;
            end
          end
          PH_PES2: begin
            if (idx == 9'd7) header_flags_next = {3'd0, b[7]};
            else if (idx == 9'd8) begin
              header_target_next = 9'd9 + 9'(b);
              if (b < 8'd5) header_flags_next = '0;
            end else if (idx == 9'd9) pts_accumulator_next = {b[2:1], 30'd0};
            else if (idx == 9'd10) pts_accumulator_next = pts_accumulator | {2'd0, b, 22'd0};
            else if (idx == 9'd11)
              pts_accumulator_next = pts_accumulator | {10'd0, b[7:1], 15'd0};
            else if (idx == 9'd12) pts_accumulator_next = pts_accumulator | {17'd0, b, 7'd0};
            else if (idx == 9'd13) begin
              pts_accumulator_next = pts_accumulator | {25'd0, b[7:1]};
              if (header_flags[0])
                res = '{1'b1, KIND_PTS, 8'd0, pts_accumulator_next, ERR_SYNC};
            end
            if (idx >= 9'd8 && idx + 9'd1 >= header_target_next) begin
              pdone = 1'b1;
              pdone_len = idx + 9'd1;
            end
          end
          PH_PES1S: pstuff = 1'b1;
          PH_PES1STD: begin
            if (idx >= header_target) begin
              pflag = 1'b1;
              pflag_idx = idx;
            end
          end
          PH_PES1X: begin
            f = header_target - (header_flags[1] ? 9'd10 : 9'd5);
            o = idx - f;
            if (o == 9'd1) pts_accumulator_next = pts_accumulator | {2'd0, b, 22'd0};
            else if (o == 9'd2)
              pts_accumulator_next = pts_accumulator | {10'd0, b[7:1], 15'd0};
            else if (o == 9'd3) pts_accumulator_next = pts_accumulator | {17'd0, b, 7'd0};
            else if (o == 9'd4) begin
              pts_accumulator_next = pts_accumulator | {25'd0, b[7:1]};
              res = '{1'b1, KIND_PTS, 8'd0, pts_accumulator_next, ERR_SYNC};
            end
            if (idx + 9'd1 >= header_target) begin
              pdone = 1'b1;
              pdone_len = idx + 9'd1;
            end
          end
          default: parse_phase_next = PH_SKIP;
        endcase
        if (pstuff) begin
          if (idx < 9'd22 && b == 8'hff) begin
            parse_phase_next = PH_PES1S;
          end else if (b[7:6] == 2'b01) begin
            parse_phase_next = PH_PES1STD;
            header_target_next = idx + 9'd2;
          end else begin
            pflag = 1'b1;
            pflag_idx = idx;
          end
        end
        if (pflag) begin
          extra = (b[7:4] == 4'h2) ? 4'd4 : ((b[7:4] == 4'h3) ? 4'd9 : 4'd0);
          if (extra == 4'd0) begin
            pdone = 1'b1;
            pdone_len = pflag_idx + 9'd1;
          end else begin
            pts_accumulator_next = {b[2:1], 30'd0};
            header_flags_next = (extra == 4'd9) ? 4'd2 : 4'd0;
            header_target_next = pflag_idx + 9'd1 + 9'(extra);
            parse_phase_next = PH_PES1X;
          end
        end
        if (pdone) begin
          if (ts) begin
            parse_phase_next = PH_DATA;
            remaining_bytes_next = '0;
          end else begin
            d = 18'd6 + 18'(pes_length) - 18'(pdone_len);
            if (!d[17] && d != '0) begin
              parse_phase_next = PH_DATA;
              remaining_bytes_next = d[16:0];
            end else begin
              parse_phase_next = PH_HUNT;
              remaining_bytes_next = '0;
            end
          end
        end
      end
      if (dsp) begin
        header_index_next = 9'd4;
        header_flags_next = '0;
        header_target_next = '0;
        if (ts) begin
          if (b >= SID_VID_LO && b <= SID_VID_HI) parse_phase_next = PH_PES;
          else begin
            parse_phase_next = PH_SKIP;
            res = '{1'b1, KIND_ERROR, 8'd0, 32'd0, ERR_STREAM_ID};
          end
        end else if (b == SID_END) begin
          parse_phase_next = PH_HUNT;
          res = '{1'b1, KIND_END, 8'd0, 32'd0, ERR_SYNC};
        end else if (b == SID_PACK) begin
          parse_phase_next = PH_PACK;
        end else if (b == stream_track) begin
          parse_phase_next = PH_PES;
        end else if (b < SID_END) begin
          parse_phase_next = PH_HUNT;
          res = '{1'b1, KIND_ERROR, 8'd0, 32'd0, ERR_NOT_SYS};
        end else begin
          parse_phase_next = PH_OTHER;
        end
      end
    end
    if (!step) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_position  <= '0;
      packet_flags     <= '0;
      adaptation_skip  <= '0;
      parse_phase      <= PH_SKIP;
      start_code_shift <= 24'hffffff;
      header_index     <= '0;
      header_target    <= '0;
      remaining_bytes  <= '0;
      pts_accumulator  <= '0;
      header_flags     <= '0;
      pes_length       <= '0;
      pid_high         <= '0;
    end else if (step) begin
      packet_position  <= packet_position_next;
      packet_flags     <= packet_flags_next;
      adaptation_skip  <= adaptation_skip_next;
      parse_phase      <= parse_phase_next;
      start_code_shift <= start_code_shift_next;
      header_index     <= header_index_next;
      header_target    <= header_target_next;
      remaining_bytes  <= remaining_bytes_next;
      pts_accumulator  <= pts_accumulator_next;
      header_flags     <= header_flags_next;
      pes_length       <= pes_length_next;
      pid_high         <= pid_high_next;
    end
  end
endmodule
